// File: hw/rtl/box_plane_set_classifier_defines.svh
// Assertion macros shared by the checker of the box classifier.
`ifndef BOX_PLANE_SET_CLASSIFIER_DEFINES_SVH
`define BOX_PLANE_SET_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define BPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box classifier check failed: same-cycle rule");

// Next-cycle implication, switched off while reset is held.
`define BPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box classifier check failed: next-cycle rule");

// Next-cycle implication that also holds across reset.
`define BPSC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("box classifier check failed: reset rule");

`endif

// File: hw/rtl/bpsc_pkg.sv
`timescale 1ns / 1ps

package bpsc_pkg;

  // Number of plane registers in the register map.
  localparam int PLANE_REGS = 6;

  // Register index width and register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LAST  = 3'd6;

  // Reset value of the plane count.
  localparam logic [2:0] PLANE_COUNT_RST = 3'd6;

  // Corners of a box, and the count when all of them are in front.
  localparam int CORNERS = 8;
  localparam logic [3:0] ALL_CORNERS = 4'd8;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
  localparam logic [1:0] VERDICT_STRADDLES = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

  // Box bounds as received.
  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } box_t;

  // Word handed from cell to cell: the box and the running result.
  typedef struct packed {
    box_t       box;
    logic [5:0] total;
    logic       outside;
    logic       full;
  } token_t;

endpackage

// File: hw/rtl/bpsc_cell.sv
`timescale 1ns / 1ps

// One plane of the chain: a product stage followed by a corner test stage.
module bpsc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       plane,
  input  logic              active,
  input  logic              up_vld,
  output logic              up_rdy,
  input  bpsc_pkg::token_t  up_tok,
  output logic              dn_vld,
  input  logic              dn_rdy,
  output bpsc_pkg::token_t  dn_tok
);

  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic signed [15:0] d;
  logic signed [32:0] off;

  logic signed [31:0] px_lo_nxt, px_hi_nxt, py_lo_nxt, py_hi_nxt;
  logic signed [31:0] pz_lo_p, pz_hi_p;
  logic signed [32:0] pz_lo_nxt, pz_hi_nxt;

  logic signed [31:0] px_lo_r, px_hi_r, py_lo_r, py_hi_r;
  logic signed [32:0] pz_lo_r, pz_hi_r;
  bpsc_pkg::token_t   a_tok_r;
  logic               a_vld_r;
  logic               a_rdy;

  logic signed [33:0] csum [bpsc_pkg::CORNERS];
  logic [7:0]         front;
  logic [3:0]         cnt;
  bpsc_pkg::token_t   b_tok_nxt;
  bpsc_pkg::token_t   b_tok_r;
  logic               b_vld_r;
  logic               b_rdy;

  // Unpack the plane: three Q2.14 normal components and an integer offset.
  assign nx  = $signed(plane[63:48]);
  assign ny  = $signed(plane[47:32]);
  assign nz  = $signed(plane[31:16]);
  assign d   = $signed(plane[15:0]);
  assign off = $signed({{3{d[15]}}, d, 14'b0});

  // Stall chain: a stage takes a new word when empty or when it hands its own on.
  assign b_rdy  = !b_vld_r || dn_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign up_rdy = a_rdy;

  // Stage A: the six axis products, the z terms carrying the offset.
  assign px_lo_nxt = nx * $signed(up_tok.box.min_x);
  assign px_hi_nxt = nx * $signed(up_tok.box.max_x);
  assign py_lo_nxt = ny * $signed(up_tok.box.min_y);
  assign py_hi_nxt = ny * $signed(up_tok.box.max_y);
  assign pz_lo_p   = nz * $signed(up_tok.box.min_z);
  assign pz_hi_p   = nz * $signed(up_tok.box.max_z);
  assign pz_lo_nxt = $signed({pz_lo_p[31], pz_lo_p}) + off;
  assign pz_hi_nxt = $signed({pz_hi_p[31], pz_hi_p}) + off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      px_lo_r <= px_lo_nxt;
      px_hi_r <= px_hi_nxt;
      py_lo_r <= py_lo_nxt;
      py_hi_r <= py_hi_nxt;
      pz_lo_r <= pz_lo_nxt;
      pz_hi_r <= pz_hi_nxt;
      a_tok_r <= up_tok;
    end
  end

  // Stage B: sum each corner, test it strictly positive and count the hits.
  always_comb begin
    cnt = 4'd0;
    for (int k = 0; k < bpsc_pkg::CORNERS; k++) begin
      csum[k] = $signed(k[2] ? {{2{px_hi_r[31]}}, px_hi_r} : {{2{px_lo_r[31]}}, px_lo_r})
              + $signed(k[1] ? {{2{py_hi_r[31]}}, py_hi_r} : {{2{py_lo_r[31]}}, py_lo_r})
              + $signed(k[0] ? {pz_hi_r[32], pz_hi_r} : {pz_lo_r[32], pz_lo_r});
      front[k] = !csum[k][33] && (csum[k] != 34'sd0);
      cnt = cnt + 4'(front[k]);
    end
  end

  // Fold this plane into the running result if the plane is in use and the box is not already out.
  always_comb begin
    b_tok_nxt = a_tok_r;
    if (active && !a_tok_r.outside) begin
      if (cnt == 4'd0) begin
        b_tok_nxt.outside = 1'b1;
      end else begin
        b_tok_nxt.total = a_tok_r.total + 6'(cnt);
        if (cnt != bpsc_pkg::ALL_CORNERS) begin
          b_tok_nxt.full = 1'b0;
        end
      end
    end
  end

  // Hold the probe word until the next cell or the output register accepts it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_tok_r <= b_tok_nxt;
    end
  end

  assign dn_vld = b_vld_r;
  assign dn_tok = b_tok_r;

endmodule

// File: hw/rtl/box_plane_set_classifier.sv
`timescale 1ns / 1ps

// Classifies an axis-aligned box against up to six planes as outside, straddling
// or inside, and counts the box corners strictly in front of the planes tested.
// One box word is accepted per clock cycle while in_stall is low; each box passes
// through the chain of plane cells (one product stage and one corner test stage per
// plane) and then the output register. Planes are taken from plane zero upward; the
// first plane with no corner in front ends the count. Write the configuration
// registers only while no box is in flight.
module box_plane_set_classifier #(
  parameter int MAX_PLANES = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_min_x,
  input  logic signed [15:0]             in_min_y,
  input  logic signed [15:0]             in_min_z,
  input  logic signed [15:0]             in_max_x,
  input  logic signed [15:0]             in_max_y,
  input  logic signed [15:0]             in_max_z,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_verdict,
  output logic [5:0]                     out_corners_in_front,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int NCELL = (MAX_PLANES < bpsc_pkg::PLANE_REGS) ? MAX_PLANES
                                                             : bpsc_pkg::PLANE_REGS;
  localparam logic [2:0] NCELL_CNT = 3'(NCELL);

  logic [2:0]       plane_count_r;
  logic [63:0]      planes_r [bpsc_pkg::PLANE_REGS];
  logic [2:0]       plane_sel;
  logic [2:0]       eff_cnt;

  logic             vld  [NCELL+1];
  logic             rdy  [NCELL+1];
  bpsc_pkg::token_t tok  [NCELL+1];

  logic             out_valid_r;
  logic [1:0]       out_verdict_r;
  logic [5:0]       out_corners_r;
  logic [1:0]       verdict_nxt;
  logic             out_rdy;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;
  assign plane_sel = cfg_index - bpsc_pkg::REG_PLANE_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= bpsc_pkg::PLANE_COUNT_RST;
      for (int i = 0; i < bpsc_pkg::PLANE_REGS; i++) begin
        planes_r[i] <= 64'd0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == bpsc_pkg::REG_PLANE_COUNT) begin
        plane_count_r <= cfg_data[2:0];
      end else if (cfg_index >= bpsc_pkg::REG_PLANE_FIRST &&
                   cfg_index <= bpsc_pkg::REG_PLANE_LAST) begin
        planes_r[plane_sel] <= cfg_data;
      end
    end
  end

  // Planes in use, clamped to the number of cells.
  assign eff_cnt = (plane_count_r > NCELL_CNT) ? NCELL_CNT : plane_count_r;

  // Word entering the chain: nothing counted yet, nothing failed.
  assign vld[0]             = in_valid;
  assign in_stall           = !rdy[0];
  assign tok[0].box.min_x   = in_min_x;
  assign tok[0].box.min_y   = in_min_y;
  assign tok[0].box.min_z   = in_min_z;
  assign tok[0].box.max_x   = in_max_x;
  assign tok[0].box.max_y   = in_max_y;
  assign tok[0].box.max_z   = in_max_z;
  assign tok[0].total       = 6'd0;
  assign tok[0].outside     = 1'b0;
  assign tok[0].full        = 1'b1;

  // One cell per plane.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    bpsc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .plane  (planes_r[g]),
      .active (3'(g) < eff_cnt),
      .up_vld (vld[g]),
      .up_rdy (rdy[g]),
      .up_tok (tok[g]),
      .dn_vld (vld[g+1]),
      .dn_rdy (rdy[g+1]),
      .dn_tok (tok[g+1])
    );
  end

  // Verdict from the flags gathered along the chain.
  always_comb begin
    if (tok[NCELL].outside) begin
      verdict_nxt = bpsc_pkg::VERDICT_OUTSIDE;
    end else if (tok[NCELL].full) begin
      verdict_nxt = bpsc_pkg::VERDICT_INSIDE;
    end else begin
      verdict_nxt = bpsc_pkg::VERDICT_STRADDLES;
    end
  end

  // Output register.
  assign out_rdy    = !out_valid_r || !out_stall;
  assign rdy[NCELL] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= vld[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_verdict_r <= verdict_nxt;
      out_corners_r <= tok[NCELL].total;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_verdict_r;
  assign out_corners_in_front = out_corners_r;

endmodule

// File: hw/rtl/bpsc_checker.sv
`timescale 1ns / 1ps
`include "box_plane_set_classifier_defines.svh"

// Watches the ports of the box classifier.
module bpsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_verdict,
  input logic [5:0]  out_corners_in_front
);

  // A result word held back by the receiver stays as it is.
  `BPSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_verdict) && $stable(out_corners_in_front))

  // The unused verdict code never appears.
  `BPSC_ASSERT_IMP(a_verdict_code, clk, rst_n, out_valid, out_verdict != 2'd3)

  // An inside box has all eight corners in front of every plane.
  `BPSC_ASSERT_IMP(a_inside_count, clk, rst_n, out_valid && out_verdict == bpsc_pkg::VERDICT_INSIDE, out_corners_in_front[2:0] == 3'd0)

  // No more than six planes of eight corners are ever counted.
  `BPSC_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, out_corners_in_front <= 6'd48)

  // Reset empties the output.
  `BPSC_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind box_plane_set_classifier bpsc_checker u_bpsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_verdict          (out_verdict),
  .out_corners_in_front (out_corners_in_front)
);

// File: tb/box_plane_set_classifier_tb.sv
`timescale 1ns / 1ps

module box_plane_set_classifier_tb;

  localparam int MAX_PLANES = 6;
  // Planes that can take part: bounded by the parameter and by the register map.
  localparam int PLANE_LIMIT = (MAX_PLANES < bpsc_pkg::PLANE_REGS) ? MAX_PLANES
                                                                   : bpsc_pkg::PLANE_REGS;
  localparam int LATENCY = 2 * PLANE_LIMIT + 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [bpsc_pkg::CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 3'd7;
  localparam logic [15:0] ONE_Q = 16'h4000;
  localparam logic [15:0] NEG_ONE_Q = 16'hC000;
  localparam logic [15:0] CUBE_EXTENT = 16'd1000;

  typedef struct packed {
    logic [1:0] verdict;
    logic [5:0] corners;
  } cull_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_min_x = '0;
  logic signed [15:0] in_min_y = '0;
  logic signed [15:0] in_min_z = '0;
  logic signed [15:0] in_max_x = '0;
  logic signed [15:0] in_max_y = '0;
  logic signed [15:0] in_max_z = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_verdict;
  logic [5:0] out_corners_in_front;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Our own copy of the register file, as it stands after reset.
  logic [2:0] plane_count_reg = bpsc_pkg::PLANE_COUNT_RST;
  logic [63:0] plane_regs [bpsc_pkg::PLANE_REGS] = '{default: '0};

  cull_result_t pending_verdicts [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  box_plane_set_classifier #(
    .MAX_PLANES(MAX_PLANES)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_min_x             (in_min_x),
    .in_min_y             (in_min_y),
    .in_min_z             (in_min_z),
    .in_max_x             (in_max_x),
    .in_max_y             (in_max_y),
    .in_max_z             (in_max_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_corners_in_front (out_corners_in_front),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Counts the corners of the box strictly in front of one packed plane.
  function automatic int unsigned count_front_corners(bpsc_pkg::box_t b,
                                                      logic [63:0] plane);
    longint nx, ny, nz, offset, x, y, z;
    int unsigned hits;
    nx = $signed(plane[63:48]);
    ny = $signed(plane[47:32]);
    nz = $signed(plane[31:16]);
    offset = $signed(plane[15:0]);
    offset = offset * 16384;
    hits = 0;
    for (int k = 0; k < bpsc_pkg::CORNERS; k++) begin
      x = k[2] ? b.max_x : b.min_x;
      y = k[1] ? b.max_y : b.min_y;
      z = k[0] ? b.max_z : b.min_z;
      if (nx * x + ny * y + nz * z + offset > 0) begin
        hits++;
      end
    end
    return hits;
  endfunction

  // Classifies a box against the planes in use, stopping at the first one it misses.
  function automatic cull_result_t classify_box(bpsc_pkg::box_t b);
    cull_result_t res;
    int unsigned active, hits, total;
    active = (plane_count_reg > PLANE_LIMIT) ? PLANE_LIMIT : plane_count_reg;
    res.verdict = bpsc_pkg::VERDICT_INSIDE;
    total = 0;
    for (int i = 0; i < active; i++) begin
      hits = count_front_corners(b, plane_regs[i]);
      if (hits == 0) begin
        res.verdict = bpsc_pkg::VERDICT_OUTSIDE;
        break;
      end
      total += hits;
    end
    if (res.verdict != bpsc_pkg::VERDICT_OUTSIDE && total != active * bpsc_pkg::CORNERS) begin
      res.verdict = bpsc_pkg::VERDICT_STRADDLES;
    end
    res.corners = total[5:0];
    return res;
  endfunction

  function automatic bpsc_pkg::box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
    bpsc_pkg::box_t b;
    b.min_x = 16'(lx);
    b.min_y = 16'(ly);
    b.min_z = 16'(lz);
    b.max_x = 16'(hx);
    b.max_y = 16'(hy);
    b.max_z = 16'(hz);
    return b;
  endfunction

  function automatic logic [63:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                             logic [15:0] nz, logic [15:0] d);
    return {nx, ny, nz, d};
  endfunction

  // Mostly small boxes around a random centre, so that all three verdicts turn up;
  // the rest take every field at random, inverted bounds included.
  function automatic bpsc_pkg::box_t random_box();
    int span, half, cx, cy, cz, hx, hy, hz;
    if ($urandom_range(99) < 30) begin
      return {$urandom(), $urandom(), $urandom()};
    end
    span = 1 << $urandom_range(14);
    half = 1 << $urandom_range(12);
    cx = int'($urandom_range(2 * span)) - span;
    cy = int'($urandom_range(2 * span)) - span;
    cz = int'($urandom_range(2 * span)) - span;
    hx = int'($urandom_range(half));
    hy = int'($urandom_range(half));
    hz = int'($urandom_range(half));
    return make_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
  endfunction

  // Axis-aligned slabs around the origin, tilted planes with a large offset,
  // and now and then a plane of random bits.
  function automatic logic [63:0] random_plane();
    logic [15:0] nrm [3];
    case ($urandom_range(3))
      0: begin
        return {$urandom(), $urandom()};
      end
      1: begin
        nrm[0] = 16'($urandom_range(16'hFFFF));
        nrm[1] = 16'($urandom_range(16'hFFFF));
        nrm[2] = 16'($urandom_range(16'hFFFF));
        return pack_plane(nrm[0], nrm[1], nrm[2],
                          16'(16'h4000 + $urandom_range(16'h3FFF)));
      end
      default: begin
        nrm = '{default: '0};
        nrm[$urandom_range(2)] = $urandom_range(1) ? ONE_Q : NEG_ONE_Q;
        return pack_plane(nrm[0], nrm[1], nrm[2], 16'($urandom_range(16'h7FFF)));
      end
    endcase
  endfunction

  // Sends one box word, idling at random first, and records what it should give.
  // Valid is left high after acceptance so that back-to-back words stay back to back.
  task automatic send_box(input bpsc_pkg::box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_min_x <= b.min_x;
    in_min_y <= b.min_y;
    in_min_z <= b.min_z;
    in_max_x <= b.max_x;
    in_max_y <= b.max_y;
    in_max_z <= b.max_z;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(classify_box(b));
  endtask

  // Holds off the input until every expected word has arrived and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bpsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bpsc_pkg::REG_PLANE_COUNT) begin
      plane_count_reg = data[2:0];
    end else if (idx >= bpsc_pkg::REG_PLANE_FIRST && idx <= bpsc_pkg::REG_PLANE_LAST) begin
      plane_regs[idx - bpsc_pkg::REG_PLANE_FIRST] = data;
    end
    @(posedge clk);
  endtask

  task automatic program_planes(input logic [2:0] count,
                                input logic [63:0] p [bpsc_pkg::PLANE_REGS]);
    wait_idle();
    cfg_write(bpsc_pkg::REG_PLANE_COUNT, {61'd0, count});
    for (int i = 0; i < bpsc_pkg::PLANE_REGS; i++) begin
      cfg_write(bpsc_pkg::REG_PLANE_FIRST + bpsc_pkg::CFG_IDX_W'(i), p[i]);
    end
  endtask

  task automatic program_cube(input logic [2:0] count);
    logic [63:0] p [bpsc_pkg::PLANE_REGS];
    p[0] = pack_plane(ONE_Q, 16'h0, 16'h0, CUBE_EXTENT);
    p[1] = pack_plane(NEG_ONE_Q, 16'h0, 16'h0, CUBE_EXTENT);
    p[2] = pack_plane(16'h0, ONE_Q, 16'h0, CUBE_EXTENT);
    p[3] = pack_plane(16'h0, NEG_ONE_Q, 16'h0, CUBE_EXTENT);
    p[4] = pack_plane(16'h0, 16'h0, ONE_Q, CUBE_EXTENT);
    p[5] = pack_plane(16'h0, 16'h0, NEG_ONE_Q, CUBE_EXTENT);
    program_planes(count, p);
  endtask

  // With the planes all zero after reset, no corner is ever in front.
  task automatic test_reset_planes();
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  // A cube of half-width 1000 around the origin.
  task automatic test_cube_planes();
    program_cube(3'd6);
    send_box(make_box(-10, -10, -10, 10, 10, 10));
    send_box(make_box(2000, -10, -10, 3000, 10, 10));
    send_box(make_box(-3000, -10, -10, -2000, 10, 10));
    send_box(make_box(-2000, -10, -10, 10, 10, 10));
    // A corner exactly on a plane is not in front of it.
    send_box(make_box(-1000, 0, 0, 0, 0, 0));
    // Inverted bounds: the corners are taken as given.
    send_box(make_box(10, 10, 10, -10, -10, -10));
    send_box(make_box(500, 500, 500, -2000, -2000, -2000));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
  endtask

  // No planes, a single plane, a count past the limit, and a write to the unused index.
  task automatic test_plane_count_limits();
    program_cube(3'd0);
    send_box(make_box(-10, -10, -10, 10, 10, 10));
    send_box(make_box(5000, 5000, 5000, 6000, 6000, 6000));
    wait_idle();
    cfg_write(bpsc_pkg::REG_PLANE_COUNT, 64'd1);
    send_box(make_box(2000, -10, -10, 3000, 10, 10));
    wait_idle();
    cfg_write(bpsc_pkg::REG_PLANE_COUNT, 64'd7);
    send_box(make_box(-2000, -10, -10, 10, 10, 10));
    wait_idle();
    cfg_write(CFG_INDEX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_box(make_box(-10, -10, -10, 10, 10, 10));
  endtask

  // Normals and offsets at the ends of their ranges.
  task automatic test_extreme_planes();
    logic [63:0] p [bpsc_pkg::PLANE_REGS];
    p[0] = pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    p[1] = pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    p[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    p[3] = pack_plane(16'h0, 16'h0, 16'h0, 16'h7FFF);
    p[4] = 64'h0;
    p[5] = pack_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h0);
    program_planes(3'd6, p);
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
  endtask

  // Random plane sets, each followed by a run of random boxes.
  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int n_items);
    logic [63:0] p [bpsc_pkg::PLANE_REGS];
    logic [2:0] count;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 5; seg++) begin
      foreach (p[i]) p[i] = random_plane();
      count = ($urandom_range(2) == 0) ? 3'($urandom_range(7)) : 3'd6;
      program_planes(count, p);
      if ($urandom_range(3) == 0) begin
        cfg_write(CFG_INDEX_UNUSED, {$urandom(), $urandom()});
      end
      for (int n = 0; n < n_items / 5; n++) begin
        send_box(random_box());
      end
    end
  endtask

  // Result side: random stall, and each accepted word checked against the oldest expected.
  always @(posedge clk) begin
    cull_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word: verdict %0d, corners_in_front %0d",
               out_verdict, out_corners_in_front);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, out_verdict);
          mismatch_count++;
        end
        if (out_corners_in_front !== want.corners) begin
          $error("corners_in_front: expected %0d, actual %0d",
                 want.corners, out_corners_in_front);
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 19;
    recv_stall_pct = 55;
    test_reset_planes();
    test_cube_planes();
    test_plane_count_limits();
    test_extreme_planes();
    test_random_traffic(19, 55, 250);
    test_random_traffic(55, 19, 250);
    test_random_traffic(0, 0, 250);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
